FILE: design/pgwalk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pgwalk_pkg
// Shared types, codes and helpers of the four-level page walk engine.
// ============================================================================
package pgwalk_pkg;

  localparam int TABLE_WORDS_DEF = 4096;
  localparam int INDEX_BITS      = 9;
  localparam int WORD_W          = 50;  // word number: (52-bit address >> 3) + index
  localparam int FRAME_W         = 40;  // entry bits 51..12
  localparam int ENTRY_W         = 64;

  localparam logic [1:0] MODE_LOAD      = 2'd0;
  localparam logic [1:0] MODE_TRANSLATE = 2'd1;
  localparam logic [1:0] MODE_MAP       = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ABSENT  = 2'd1,
    STAT_OUTSIDE = 2'd2,
    STAT_LARGE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    W_CLEAR,
    W_IDLE,
    W_WALK,
    W_HOLD
  } walk_state_t;

  typedef struct packed {
    logic present;
    logic writable;
    logic user;
    logic no_execute;
    logic cache_disable;
    logic write_through;
  } flags_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] virt_addr;
    logic [51:0] page_addr;
    logic [11:0] mem_word_index;
    logic [63:0] mem_data;
    flags_t      flags;
  } req_t;

  typedef struct packed {
    logic [51:0] result_addr;
    status_t     status;
    logic        leaf_writable;
    logic        leaf_user;
    logic        leaf_no_execute;
    logic        leaf_cache_disable;
    logic        leaf_accessed;
    logic [3:0]  leaf_protection_key;
  } res_t;

  // Word number of entry idx in the table whose frame is given.
  function automatic logic [WORD_W-1:0] word_of(input logic [FRAME_W-1:0] frame,
                                                input logic [INDEX_BITS-1:0] idx);
    word_of = {1'b0, frame, {INDEX_BITS{1'b0}}} + {{(WORD_W-INDEX_BITS){1'b0}}, idx};
  endfunction

  // Index slice of the virtual address for level 0..3.
  function automatic logic [INDEX_BITS-1:0] va_idx(input logic [47:0] va,
                                                   input logic [1:0] lvl);
    case (lvl)
      2'd0:    va_idx = va[47:39];
      2'd1:    va_idx = va[38:30];
      2'd2:    va_idx = va[29:21];
      default: va_idx = va[20:12];
    endcase
  endfunction

  function automatic res_t make_res(input logic [51:0] addr, input status_t st,
                                    input logic [ENTRY_W-1:0] e);
    res_t r;
    r.result_addr         = addr;
    r.status              = st;
    r.leaf_writable       = e[1];
    r.leaf_user           = e[2];
    r.leaf_no_execute     = e[63];
    r.leaf_cache_disable  = e[4];
    r.leaf_accessed       = e[5];
    r.leaf_protection_key = e[62:59];
    make_res = r;
  endfunction

  function automatic res_t fail_res(input status_t st);
    fail_res = make_res(52'd0, st, {ENTRY_W{1'b0}});
  endfunction

endpackage
`default_nettype wire

FILE: design/four_level_page_walk_and_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// four_level_page_walk_and_map
// Page-table engine over a built-in table memory: load a word, translate a
// virtual address through four levels, or map a page by updating its leaf.
// ============================================================================
//
//  channel | dir | handshake           | transaction
//  --------+-----+---------------------+-----------------------------------
//  in_     | in  | in_valid / in_stall | one request (load, translate, map)
//  out_    | out | out_valid/out_stall | one result per request
//  cfg_    | in  | cfg_valid/cfg_ready | root table base write
//
//  Modes: load and the unused mode finish on acceptance; translate and map
//  walk level by level, as the accept cycle issues the first read and each
//  level's address comes from the previous entry through the one read port.
//  Map writes the leaf last. Reset: a clearing pass zeroes the table, in_stall
//  high meanwhile, config still taken. Stalls: a result waits in the output
//  register; the next one waits in a one-entry hold in the walker.
//
module four_level_page_walk_and_map import pgwalk_pkg::*; #(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [51:0] cfg_root_table_base,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [47:0] in_virt_addr,
  input  wire logic [51:0] in_page_addr,
  input  wire logic [11:0] in_mem_word_index,
  input  wire logic [63:0] in_mem_data,
  input  wire logic        in_flag_present,
  input  wire logic        in_flag_writable,
  input  wire logic        in_flag_user,
  input  wire logic        in_flag_no_execute,
  input  wire logic        in_flag_cache_disable,
  input  wire logic        in_flag_write_through,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [51:0]      out_result_addr,
  output logic [1:0]       out_status,
  output logic             out_leaf_writable,
  output logic             out_leaf_user,
  output logic             out_leaf_no_execute,
  output logic             out_leaf_cache_disable,
  output logic             out_leaf_accessed,
  output logic [3:0]       out_leaf_protection_key
);

  localparam int AW = $clog2(TABLE_WORDS);

  // Root base register; the low 12 bits never reach the walk.
  logic [51:0] root_r;

  req_t  req;
  res_t  res;
  logic  res_valid;
  logic  res_ready;

  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;

  // Output register
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_r <= cfg_root_table_base;
    end
  end

  always_comb begin
    req.mode                = in_mode;
    req.virt_addr           = in_virt_addr;
    req.page_addr           = in_page_addr;
    req.mem_word_index      = in_mem_word_index;
    req.mem_data            = in_mem_data;
    req.flags.present       = in_flag_present;
    req.flags.writable      = in_flag_writable;
    req.flags.user          = in_flag_user;
    req.flags.no_execute    = in_flag_no_execute;
    req.flags.cache_disable = in_flag_cache_disable;
    req.flags.write_through = in_flag_write_through;
  end

  pgwalk_walker #(
    .TABLE_WORDS (TABLE_WORDS),
    .AW          (AW)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .root_base   (root_r),
    .req_valid   (in_valid),
    .req         (req),
    .req_stall   (in_stall),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  pgwalk_mem #(
    .TABLE_WORDS (TABLE_WORDS),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_result_addr         = out_r.result_addr;
  assign out_status              = out_r.status;
  assign out_leaf_writable       = out_r.leaf_writable;
  assign out_leaf_user           = out_r.leaf_user;
  assign out_leaf_no_execute     = out_r.leaf_no_execute;
  assign out_leaf_cache_disable  = out_r.leaf_cache_disable;
  assign out_leaf_accessed       = out_r.leaf_accessed;
  assign out_leaf_protection_key = out_r.leaf_protection_key;

endmodule
`default_nettype wire

FILE: design/pgwalk_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pgwalk_mem
// Table memory: one write port, one read port, registered read data.
// ============================================================================
module pgwalk_mem import pgwalk_pkg::*; #(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  parameter int AW          = $clog2(TABLE_WORDS)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [TABLE_WORDS];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: design/pgwalk_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pgwalk_walker
// Walk sequencer: clearing pass, load, per-level read/check, leaf update,
// and a one-entry hold for a result the output stage cannot take yet.
// ============================================================================
module pgwalk_walker import pgwalk_pkg::*; #(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  parameter int AW          = $clog2(TABLE_WORDS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [51:0]        root_base,
  input  wire logic               req_valid,
  input  wire req_t               req,
  output logic                    req_stall,
  output logic                    res_valid,
  output res_t                    res,
  input  wire logic               res_ready,
  output logic                    mem_wr_en,
  output logic      [AW-1:0]      mem_wr_addr,
  output logic      [ENTRY_W-1:0] mem_wr_data,
  output logic                    mem_rd_en,
  output logic      [AW-1:0]      mem_rd_addr,
  input  wire logic [ENTRY_W-1:0] mem_rd_data
);

  localparam logic [WORD_W-1:0] LIMIT = WORD_W'(TABLE_WORDS);
  localparam logic [AW-1:0]     LAST  = AW'(TABLE_WORDS - 1);

  walk_state_t         state_r, state_nxt;
  logic [1:0]          lvl_r, lvl_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                is_map_r;
  logic [47:0]         va_r;
  logic [FRAME_W-1:0]  pa_frame_r;
  flags_t              flags_r;
  logic [AW-1:0]       word_r;
  res_t                hold_r;

  logic                accept;
  logic                fin_valid;
  res_t                fin_res;
  logic [WORD_W-1:0]   first_word, next_word, ld_word;
  logic [ENTRY_W-1:0]  e, new_e;

  assign accept = req_valid && (state_r == W_IDLE);
  assign e      = mem_rd_data;

  assign first_word = word_of(root_base[51:12], req.virt_addr[47:39]);
  assign next_word  = word_of(e[51:12], va_idx(va_r, lvl_r + 2'd1));
  assign ld_word    = WORD_W'(req.mem_word_index);

  // Leaf as map writes it: frame and flags replaced, bits 5..11 and 52..62 kept.
  assign new_e = {flags_r.no_execute, e[62:52], pa_frame_r, e[11:5],
                  flags_r.cache_disable, flags_r.write_through, flags_r.user,
                  flags_r.writable, flags_r.present};

  always_comb begin
    state_nxt   = state_r;
    lvl_nxt     = lvl_r;
    clr_cnt_nxt = clr_cnt_r;
    fin_valid   = 1'b0;
    fin_res     = fail_res(STAT_OK);
    mem_wr_en   = 1'b0;
    mem_wr_addr = word_r;
    mem_wr_data = new_e;
    mem_rd_en   = 1'b0;
    mem_rd_addr = next_word[AW-1:0];

    case (state_r)
      W_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_r;
        mem_wr_data = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST) begin
          state_nxt = W_IDLE;
        end
      end
      W_IDLE: begin
        if (accept) begin
          case (req.mode)
            MODE_LOAD: begin
              mem_wr_en   = (ld_word < LIMIT);
              mem_wr_addr = ld_word[AW-1:0];
              mem_wr_data = req.mem_data;
              fin_valid   = 1'b1;
            end
            MODE_TRANSLATE, MODE_MAP: begin
              if (first_word < LIMIT) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = first_word[AW-1:0];
                lvl_nxt     = 2'd0;
                state_nxt   = W_WALK;
              end else begin
                fin_valid = 1'b1;
                fin_res   = fail_res(STAT_OUTSIDE);
              end
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      W_WALK: begin
        if (lvl_r != 2'd3) begin
          if (!e[0]) begin
            fin_valid = 1'b1;
            fin_res   = fail_res(STAT_ABSENT);
          end else if (lvl_r == 2'd2 && e[7]) begin
            // 2 MiB page at the directory level
            fin_valid = 1'b1;
            fin_res   = is_map_r ? fail_res(STAT_LARGE)
                                 : make_res({e[51:21], va_r[20:0]}, STAT_OK, e);
          end else if (next_word < LIMIT) begin
            mem_rd_en = 1'b1;
            lvl_nxt   = lvl_r + 2'd1;
          end else begin
            fin_valid = 1'b1;
            fin_res   = fail_res(STAT_OUTSIDE);
          end
        end else if (is_map_r) begin
          mem_wr_en = 1'b1;
          fin_valid = 1'b1;
          fin_res   = make_res(52'd0, STAT_OK, new_e);
        end else begin
          fin_valid = 1'b1;
          fin_res   = e[0] ? make_res({e[51:12], va_r[11:0]}, STAT_OK, e)
                           : fail_res(STAT_ABSENT);
        end
      end
      W_HOLD: begin
        if (res_ready) begin
          state_nxt = W_IDLE;
        end
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase

    if (fin_valid) begin
      state_nxt = res_ready ? W_IDLE : W_HOLD;
    end
  end

  assign req_stall = (state_r != W_IDLE);
  assign res_valid = (state_r == W_HOLD) || fin_valid;
  assign res       = (state_r == W_HOLD) ? hold_r : fin_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= W_CLEAR;
      lvl_r     <= 2'd0;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      lvl_r     <= lvl_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_map_r   <= (req.mode == MODE_MAP);
      va_r       <= req.virt_addr;
      pa_frame_r <= req.page_addr[51:12];
      flags_r    <= req.flags;
    end
    if (mem_rd_en) begin
      word_r <= mem_rd_addr;
    end
    if (fin_valid) begin
      hold_r <= fin_res;
    end
  end

endmodule
`default_nettype wire
